// ----- design/svia_pkg.sv -----
// svia_pkg: shared constants and command codes for the stack vm integer alu
// no dependencies
package svia_pkg;
    localparam int WordWidthDefault = 32;
    localparam int FieldWidth = 32;
    localparam int CmdWidth = 4;

    typedef enum logic [CmdWidth-1:0] {
        CMD_NOT  = 4'd0,
        CMD_AND  = 4'd1,
        CMD_OR   = 4'd2,
        CMD_XOR  = 4'd3,
        CMD_LSH  = 4'd4,
        CMD_RSH  = 4'd5,
        CMD_ARSH = 4'd6,
        CMD_EQ   = 4'd7,
        CMD_LT   = 4'd8,
        CMD_NEG  = 4'd9,
        CMD_ADD  = 4'd10,
        CMD_MUL  = 4'd11,
        CMD_DIV  = 4'd12,
        CMD_REM  = 4'd13,
        CMD_POW  = 4'd14,
        CMD_BAD  = 4'd15
    } t_cmd;

    typedef enum logic [1:0] {
        UOP_ADD  = 2'd0,
        UOP_SUB  = 2'd1,
        UOP_PASS = 2'd2
    } t_uop;

    typedef struct packed {
        t_uop op;
    } t_unit_ctl;
endpackage

// ----- design/svia_addsub.sv -----
// svia_addsub: shared add/subtract/pass unit used by the sequencer
// depends on svia_pkg
module svia_addsub #(
    parameter int WORD_WIDTH = svia_pkg::WordWidthDefault
) (
    input  svia_pkg::t_unit_ctl   i_ctl,
    input  logic [WORD_WIDTH-1:0] i_a,
    input  logic [WORD_WIDTH-1:0] i_b,
    output logic [WORD_WIDTH-1:0] o_sum,
    output logic                  o_carry
);
    logic [WORD_WIDTH:0] w_res;
    always_comb begin
        case (i_ctl.op)
            svia_pkg::UOP_ADD: w_res = {1'b0, i_a} + {1'b0, i_b};
            svia_pkg::UOP_SUB: w_res = {1'b0, i_a} + {1'b0, ~i_b} + {{WORD_WIDTH{1'b0}}, 1'b1};
            default:           w_res = {1'b0, i_a};
        endcase
    end
    assign o_sum   = w_res[WORD_WIDTH-1:0];
    assign o_carry = w_res[WORD_WIDTH];
endmodule

// ----- design/stack_vm_integer_alu.sv -----
// stack_vm_integer_alu: top level with command decode and multi-cycle sequencer
// depends on svia_pkg and svia_addsub
//
//  channel | valid   | stall   | payload
//  in      | i_valid | o_stall | i_command, i_top_operand, i_second_operand
//  out     | o_valid | i_stall | o_result_value, o_status
//
// logic ops, shifts, compares, neg, add: ST_SIMPLE, then ST_DONE for the output handshake
// mul: WORD_WIDTH shift-add steps on the shared adder, then ST_DONE
// div: two abs passes, WORD_WIDTH steps, fixup; rem: one ST_DIV_PRE pass with no abs, WORD_WIDTH steps, fixup
// pow: per exponent bit up to the top set one, a check state, a WORD_WIDTH-step multiply
//   when the bit is set and then a WORD_WIDTH-step square, then a final check
// reset is synchronous, active low; input stalls until the result word is taken
module stack_vm_integer_alu #(
    parameter int WORD_WIDTH = svia_pkg::WordWidthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_command,
    input  logic signed [31:0] i_top_operand,
    input  logic signed [31:0] i_second_operand,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_result_value,
    output logic        o_status
);
    localparam int W = WORD_WIDTH;
    localparam int CW = $clog2(W + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SIMPLE, ST_MUL, ST_DIV_PRE, ST_DIV, ST_DIV_FIX,
        ST_POW_CHK, ST_POW_MUL, ST_POW_SQ, ST_DONE
    } t_state;

    t_state r_state;
    svia_pkg::t_cmd r_cmd;
    logic [W-1:0] r_t, r_s, r_acc, r_mc, r_mp, r_pb, r_pe, r_pr;
    logic [CW-1:0] r_cnt;
    logic r_neg, r_pow_sq;
    logic [31:0] r_out;
    logic r_st;

    logic [W-1:0] w_t, w_s;
    always_comb begin
        w_t = W'($signed(i_top_operand));
        w_s = W'($signed(i_second_operand));
    end

    svia_pkg::t_unit_ctl w_ctl;
    logic [W-1:0] w_a, w_b, w_sum;
    logic w_carry;
    svia_addsub #(.WORD_WIDTH(W)) u_addsub (
        .i_ctl(w_ctl), .i_a(w_a), .i_b(w_b), .o_sum(w_sum), .o_carry(w_carry)
    );

    // divide: r_acc holds remainder, r_mp holds quotient/dividend bits, r_mc divisor
    logic [W-1:0] w_rem_sh;
    assign w_rem_sh = {r_acc[W-2:0], r_mp[W-1]};

    always_comb begin
        w_ctl.op = svia_pkg::UOP_PASS;
        w_a = r_acc;
        w_b = r_mc;
        unique case (r_state)
            ST_SIMPLE: begin
                w_a = r_s;
                w_b = r_t;
                w_ctl.op = (r_cmd == svia_pkg::CMD_ADD) ? svia_pkg::UOP_ADD
                                                         : svia_pkg::UOP_SUB;
                if (r_cmd == svia_pkg::CMD_NEG) begin
                    w_a = '0;
                end
                if (r_cmd == svia_pkg::CMD_LT) begin
                    w_a = r_t ^ {1'b1, {(W-1){1'b0}}};
                    w_b = r_s ^ {1'b1, {(W-1){1'b0}}};
                end
            end
            ST_MUL: begin
                w_ctl.op = r_mp[0] ? svia_pkg::UOP_ADD : svia_pkg::UOP_PASS;
            end
            ST_DIV_PRE: begin
                w_ctl.op = svia_pkg::UOP_SUB;
                w_a = '0;
                w_b = (r_cnt == '0) ? r_mc : r_mp;
            end
            ST_DIV: begin
                w_ctl.op = svia_pkg::UOP_SUB;
                w_a = w_rem_sh;
            end
            ST_DIV_FIX: begin
                w_ctl.op = svia_pkg::UOP_SUB;
                w_a = '0;
                w_b = r_mp;
            end
            default: ;
        endcase
    end

    logic [CW-1:0] w_sh;
    logic w_big;
    always_comb begin
        w_big = (r_t >= W'(W));
        w_sh = r_t[CW-1:0];
    end

    logic [W-1:0] w_simple;
    logic w_simple_bad;
    always_comb begin
        w_simple = '0;
        w_simple_bad = 1'b0;
        case (r_cmd)
            svia_pkg::CMD_NOT: w_simple = ~r_t;
            svia_pkg::CMD_AND: w_simple = r_t & r_s;
            svia_pkg::CMD_OR:  w_simple = r_t | r_s;
            svia_pkg::CMD_XOR: w_simple = r_t ^ r_s;
            svia_pkg::CMD_LSH: w_simple = w_big ? '0 : (r_s << w_sh);
            svia_pkg::CMD_RSH: w_simple = w_big ? '0 : (r_s >> w_sh);
            svia_pkg::CMD_ARSH: w_simple = w_big ? {W{r_s[W-1]}}
                                                 : W'($signed(r_s) >>> w_sh);
            svia_pkg::CMD_EQ:  w_simple = W'(r_t == r_s);
            svia_pkg::CMD_LT:  w_simple = W'(!w_carry);
            svia_pkg::CMD_NEG, svia_pkg::CMD_ADD: w_simple = w_sum;
            default: w_simple_bad = 1'b1;
        endcase
    end

    function automatic logic [31:0] to_field(input logic [W-1:0] v);
        logic [63:0] e;
        e = 64'($signed(v));
        return e[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= svia_pkg::t_cmd'(i_command);
                        r_t <= w_t;
                        r_s <= w_s;
                        r_acc <= '0;
                        r_cnt <= '0;
                        case (svia_pkg::t_cmd'(i_command))
                            svia_pkg::CMD_MUL: begin
                                r_mc <= w_t;
                                r_mp <= w_s;
                                r_state <= ST_MUL;
                            end
                            svia_pkg::CMD_DIV, svia_pkg::CMD_REM: begin
                                // load divisor into r_mc and dividend into r_mp for the abs passes
                                r_mc <= w_t;
                                r_mp <= w_s;
                                r_state <= ST_DIV_PRE;
                            end
                            svia_pkg::CMD_POW: begin
                                r_pb <= w_t;
                                r_pe <= w_s;
                                r_pr <= {{(W-1){1'b0}}, 1'b1};
                                r_state <= ST_POW_CHK;
                            end
                            default: r_state <= ST_SIMPLE;
                        endcase
                    end
                end
                ST_SIMPLE: begin
                    r_out <= to_field(w_simple);
                    r_st <= w_simple_bad;
                    r_state <= ST_DONE;
                end
                ST_MUL: begin
                    if (r_cnt == CW'(W - 1)) begin
                        if (r_cmd == svia_pkg::CMD_MUL) begin
                            r_out <= to_field(w_sum);
                            r_st <= 1'b0;
                            r_state <= ST_DONE;
                        end else if (r_pow_sq) begin
                            r_pb <= w_sum;
                            r_pe <= r_pe >> 1;
                            r_state <= ST_POW_CHK;
                        end else begin
                            r_pr <= w_sum;
                            r_pow_sq <= 1'b1;
                            r_acc <= '0;
                            r_cnt <= '0;
                            r_mc <= r_pb;
                            r_mp <= r_pb;
                        end
                    end else begin
                        r_acc <= w_sum;
                        r_mc <= r_mc << 1;
                        r_mp <= r_mp >> 1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_POW_CHK: begin
                    r_acc <= '0;
                    r_cnt <= '0;
                    if (r_pe == '0) begin
                        r_out <= to_field(r_pr);
                        r_st <= 1'b0;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_MUL;
                        r_pow_sq <= !r_pe[0];
                        r_mc <= r_pe[0] ? r_pr : r_pb;
                        r_mp <= r_pb;
                    end
                end
                ST_DIV_PRE: begin
                    // two passes for signed div: first divisor abs, then dividend abs; rem skips both
                    if (r_cmd == svia_pkg::CMD_REM) begin
                        r_neg <= 1'b0;
                        r_cnt <= '0;
                        r_state <= ST_DIV;
                    end else if (r_cnt == '0) begin
                        r_neg <= r_s[W-1] ^ r_t[W-1];
                        if (r_mc[W-1]) r_mc <= w_sum;
                        r_cnt <= CW'(1);
                    end else begin
                        if (r_mp[W-1]) r_mp <= w_sum;
                        r_cnt <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (!w_carry) begin
                        r_acc <= w_rem_sh;
                        r_mp <= {r_mp[W-2:0], 1'b0};
                    end else begin
                        r_acc <= w_sum;
                        r_mp <= {r_mp[W-2:0], 1'b1};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(W - 1)) r_state <= ST_DIV_FIX;
                end
                ST_DIV_FIX: begin
                    r_st <= 1'b0;
                    if (r_t == '0) begin
                        r_out <= (r_cmd == svia_pkg::CMD_REM) ? to_field(r_s) : '0;
                    end else if (r_cmd == svia_pkg::CMD_REM) begin
                        r_out <= to_field(r_acc);
                    end else begin
                        r_out <= to_field(r_neg ? w_sum : r_mp);
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!i_stall) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_DONE);
    assign o_result_value = r_out;
    assign o_status = r_st;

    a_done_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("result shown while taking input");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result_value)))
        else $error("stalled result changed");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_result_value == 32'd0))
        else $error("invalid code with nonzero result");
endmodule

// ----- tb/sv/tb_stack_vm_integer_alu_checker.sv -----
// tb_stack_vm_integer_alu_checker: watches both channels of the integer alu, predicts each
// result word from the accepted input word and compares field by field
// depends on svia_pkg
module tb_stack_vm_integer_alu_checker #(
    parameter int WORD_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic [3:0]         i_command,
    input  logic signed [31:0] i_top_operand,
    input  logic signed [31:0] i_second_operand,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_result_value,
    input  logic               i_status,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        logic        status;
    } t_alu_word;

    localparam logic [WORD_WIDTH-1:0] WordOnes = '1;
    localparam logic [WORD_WIDTH-1:0] SignBit = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    t_alu_word expected_words[$];
    int        fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_words.size();

    function automatic logic [WORD_WIDTH-1:0] to_word(logic [31:0] f);
        logic [63:0] wide;
        wide = {{32{f[31]}}, f};
        return wide[WORD_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] to_field(logic [WORD_WIDTH-1:0] w);
        logic [63:0] wide;
        wide = 64'($signed(w));
        return wide[31:0];
    endfunction

    function automatic logic [WORD_WIDTH-1:0] raise_power(logic [WORD_WIDTH-1:0] base,
                                                         logic [WORD_WIDTH-1:0] ex);
        logic [WORD_WIDTH-1:0] acc;
        acc = WORD_WIDTH'(1);
        while (ex != 0) begin
            if (ex[0]) acc = acc * base;
            ex = ex >> 1;
            base = base * base;
        end
        return acc;
    endfunction

    function automatic t_alu_word predict_alu(logic [3:0] cmd, logic [31:0] top_f,
                                              logic [31:0] sec_f);
        logic [WORD_WIDTH-1:0] t, s, r, q, at, as_;
        t_alu_word res;
        t = to_word(top_f);
        s = to_word(sec_f);
        r = '0;
        res.status = 1'b0;
        case (svia_pkg::t_cmd'(cmd))
            svia_pkg::CMD_NOT:  r = ~t;
            svia_pkg::CMD_AND:  r = t & s;
            svia_pkg::CMD_OR:   r = t | s;
            svia_pkg::CMD_XOR:  r = t ^ s;
            svia_pkg::CMD_LSH:  r = (t < WORD_WIDTH) ? s << t : '0;
            svia_pkg::CMD_RSH:  r = (t < WORD_WIDTH) ? s >> t : '0;
            svia_pkg::CMD_ARSH: r = (t < WORD_WIDTH) ? WORD_WIDTH'($signed(s) >>> t)
                                                     : (s[WORD_WIDTH-1] ? WordOnes : '0);
            svia_pkg::CMD_EQ:   r = WORD_WIDTH'(t == s);
            svia_pkg::CMD_LT:   r = WORD_WIDTH'((t ^ SignBit) < (s ^ SignBit));
            svia_pkg::CMD_NEG:  r = -t;
            svia_pkg::CMD_ADD:  r = s + t;
            svia_pkg::CMD_MUL:  r = s * t;
            svia_pkg::CMD_DIV: begin
                if (t == 0) begin
                    r = '0;
                end else begin
                    at = t[WORD_WIDTH-1] ? -t : t;
                    as_ = s[WORD_WIDTH-1] ? -s : s;
                    q = as_ / at;
                    r = (t[WORD_WIDTH-1] ^ s[WORD_WIDTH-1]) ? -q : q;
                end
            end
            svia_pkg::CMD_REM:  r = (t == 0) ? s : s % t;
            svia_pkg::CMD_POW:  r = raise_power(t, s);
            default: begin
                r = '0;
                res.status = 1'b1;
            end
        endcase
        res.value = to_field(r);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_alu_word want;
        if (i_rst_n) begin
            if (i_valid && !i_in_stall)
                expected_words.push_back(predict_alu(i_command, i_top_operand,
                                                     i_second_operand));
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", i_result_value, 32'd0);
                end else begin
                    want = expected_words.pop_front();
                    if (i_result_value !== want.value)
                        report_mismatch("result_value", i_result_value, want.value);
                    if (i_status !== want.status)
                        report_mismatch("status", 32'(i_status), 32'(want.status));
                end
            end
        end
    end
endmodule

// ----- tb/sv/tb_stack_vm_integer_alu.sv -----
// tb_stack_vm_integer_alu: directed and random commands for the integer alu with random
// gaps and output stalls; depends on svia_pkg, the alu and its checker
module tb_stack_vm_integer_alu;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomWords = 850;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [3:0]         i_command = '0;
    logic signed [31:0] i_top_operand = '0;
    logic signed [31:0] i_second_operand = '0;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic signed [31:0] o_result_value;
    logic               o_status;
    int                 fail_count;
    int                 pending;
    bit                 quiet_gaps = 1'b0;
    int                 out_wait = 0;

    always #1 i_clk = ~i_clk;

    stack_vm_integer_alu u_top (.*);

    tb_stack_vm_integer_alu_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_command, .i_top_operand,
        .i_second_operand, .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_result_value(o_result_value), .i_status(o_status),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    task automatic send_word(svia_pkg::t_cmd cmd, logic [31:0] top_v, logic [31:0] sec_v);
        int gap;
        gap = quiet_gaps ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_top_operand <= top_v;
        i_second_operand <= sec_v;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 40);
            1: return -$urandom_range(0, 3);
            2: return 32'h8000_0000 ^ $urandom_range(0, 1);
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // per result word: hold stall for a drawn number of cycles
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            out_wait = quiet_gaps ? 0 : $urandom_range(0, 15);
        end else if (out_wait != 0) begin
            out_wait = out_wait - 1;
        end
        i_stall <= (out_wait != 0);
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        svia_pkg::t_cmd cmd;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int c = 0; c < 16; c++)
            send_word(svia_pkg::t_cmd'(c), 32'hffff_ffff, 32'h8000_0000);
        send_word(svia_pkg::CMD_LSH, 32, 32'h0000_0001);
        send_word(svia_pkg::CMD_ARSH, 32'hffff_ffff, 32'h8000_0000);
        send_word(svia_pkg::CMD_ARSH, 31, 32'h8000_0000);
        send_word(svia_pkg::CMD_RSH, 33, 32'hffff_ffff);
        send_word(svia_pkg::CMD_DIV, 0, 32'h7fff_ffff);
        send_word(svia_pkg::CMD_DIV, 32'hffff_ffff, 32'h8000_0000);
        send_word(svia_pkg::CMD_DIV, 32'h8000_0000, 32'h8000_0000);
        send_word(svia_pkg::CMD_REM, 0, 32'h8000_0001);
        send_word(svia_pkg::CMD_POW, 32'h7fff_ffff, 0);
        send_word(svia_pkg::CMD_LT, 32'h7fff_ffff, 32'h8000_0000);
        for (int n = 0; n < RandomWords; n++) begin
            quiet_gaps = ((n / 100) % 3 == 2);
            cmd = svia_pkg::t_cmd'($urandom_range(0, 15));
            send_word(cmd, pick_operand(), pick_operand());
        end
        i_valid <= 1'b0;
        quiet_gaps = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
